// File: src/fbs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the blur kernel for the fire blur stream unit.
// No dependencies.
package fbs_pkg;

  localparam int PIX_W          = 8;
  localparam int LINE_WIDTH_W   = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_INDEX_W    = 2;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Reset geometry, stored as last column / last row.
  localparam logic [LINE_WIDTH_W-1:0]   W_LAST_RST = LINE_WIDTH_W'(640 - 1);
  localparam logic [FRAME_HEIGHT_W-1:0] H_LAST_RST = FRAME_HEIGHT_W'(480 - 1);

  localparam logic [PIX_W-1:0] BLUR_BIAS = PIX_W'(2);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  // Effective frame geometry plus a restart strobe on any register write.
  typedef struct packed {
    logic                      restart;
    logic [LINE_WIDTH_W-1:0]   w_last;
    logic [FRAME_HEIGHT_W-1:0] h_last;
  } geom_t;

  // floor(sum of four neighbors / 4) - 2, floored at zero.
  function automatic pix_t blur4(input pix_t up, input pix_t down,
                                 input pix_t left, input pix_t right);
    logic [PIX_W+1:0] sum;
    pix_t             avg;
    sum = {2'b00, up} + {2'b00, down} + {2'b00, left} + {2'b00, right};
    avg = sum[PIX_W+1:2];
    return (avg >= BLUR_BIAS) ? avg - BLUR_BIAS : '0;
  endfunction

endpackage

// File: src/fbs_row_mem.sv
`timescale 1ns / 1ps
// One-row line store: single write port, single read port with registered data.
// Depends on fbs_pkg for the pixel type.
module fbs_row_mem #(
  parameter int DEPTH = fbs_pkg::DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  fbs_pkg::pix_t            wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output fbs_pkg::pix_t            rd_data
);

  fbs_pkg::pix_t mem [DEPTH];
  fbs_pkg::pix_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/fbs_cfg.sv
`timescale 1ns / 1ps
// Configuration registers: decode writes, clamp width and height to legal range.
// Depends on fbs_pkg for register codes and the geometry struct.
module fbs_cfg #(
  parameter int MAX_WIDTH  = fbs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fbs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fbs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fbs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output fbs_pkg::geom_t                     geom
);

  localparam int LW = fbs_pkg::LINE_WIDTH_W;
  localparam int HW = fbs_pkg::FRAME_HEIGHT_W;
  localparam logic [LW-1:0] W_LAST_MAX =
    LW'(((MAX_WIDTH > (1 << LW)) ? (1 << LW) : MAX_WIDTH) - 1);
  localparam logic [HW-1:0] H_LAST_MAX =
    HW'(((MAX_HEIGHT > (1 << HW)) ? (1 << HW) : MAX_HEIGHT) - 1);

  logic [LW-1:0] w_last_r, w_last_nxt;
  logic [HW-1:0] h_last_r, h_last_nxt;
  logic          restart;
  logic [LW-1:0] lw;
  logic [HW-1:0] fh;

  assign cfg_ready = 1'b1;
  assign lw = cfg_data[LW-1:0];
  assign fh = cfg_data[HW-1:0];

  always_comb begin
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    restart    = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        fbs_pkg::REG_LINE_WIDTH: begin
          restart = 1'b1;
          if (lw < LW'(3))                 w_last_nxt = LW'(2);
          else if (lw - LW'(1) > W_LAST_MAX) w_last_nxt = W_LAST_MAX;
          else                             w_last_nxt = lw - LW'(1);
        end
        fbs_pkg::REG_FRAME_HEIGHT: begin
          restart = 1'b1;
          if (fh < HW'(3))                 h_last_nxt = HW'(2);
          else if (fh - HW'(1) > H_LAST_MAX) h_last_nxt = H_LAST_MAX;
          else                             h_last_nxt = fh - HW'(1);
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= fbs_pkg::W_LAST_RST;
      h_last_r <= fbs_pkg::H_LAST_RST;
    end else begin
      w_last_r <= w_last_nxt;
      h_last_r <= h_last_nxt;
    end
  end

  assign geom.restart = restart;
  assign geom.w_last  = w_last_r;
  assign geom.h_last  = h_last_r;

endmodule

// File: src/fire_blur_stream_unit.sv
`timescale 1ns / 1ps
// Top level of the fire blur stream unit: scan counters, blur datapath, result register.
// Depends on fbs_pkg, fbs_cfg and fbs_row_mem.
//
// Usage:
//   Pixels enter in raster order on the in_ channel (in_valid/in_ready, one
//   word per accepted handshake). The blurred frame leaves on the out_ channel
//   one row behind: while input row r is taken in, row r-1 is emitted, so the
//   bottom row never appears and input row 0 produces no words.
//   out_frame_done flags the last emitted word of each frame.
//   Throughput is one pixel per clock while in_ready stays high. The result
//   of an accepted word is registered and shows on out_ in the next cycle.
//   The two line stores have registered read ports, so the read for the next column
//   is issued from the counters' next values; that prefetch is what sets the rate.
//   in_ready drops only while a result sits in the output register and the
//   receiver holds out_ready low; a word that makes no result then waits too.
//   Reset clears the counters and the output valid flag and loads 640 x 480.
//   A write to either cfg_ register restarts the frame; write only while idle.
//   Line stores are not cleared; entries are always written before read.
module fire_blur_stream_unit #(
  parameter int MAX_WIDTH  = fbs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fbs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fbs_pkg::PIX_W-1:0]       in_pixel_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fbs_pkg::PIX_W-1:0]       out_pixel_out,
  output logic                            out_frame_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fbs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CW = (COL_W > fbs_pkg::LINE_WIDTH_W) ? COL_W : fbs_pkg::LINE_WIDTH_W;
  localparam int RW = (ROW_W > fbs_pkg::FRAME_HEIGHT_W) ? ROW_W : fbs_pkg::FRAME_HEIGHT_W;

  fbs_pkg::geom_t geom;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  fbs_pkg::pix_t    left_r, left_nxt;
  logic             out_valid_r, out_valid_nxt;
  fbs_pkg::pix_t    pixel_out_r, pixel_out_nxt;
  logic             frame_done_r, frame_done_nxt;

  logic [CW-1:0]    col_ext, w_last_ext;
  logic [RW-1:0]    row_ext, h_last_ext;
  logic             accept, at_row_end, at_last_row, row_zero, row_one;
  logic             edge_col, right_edge_next, emit;

  fbs_pkg::pix_t    above_q, orig_q, right_px, blur_px, result_px, above_wr;
  logic [COL_W-1:0] orig_rd_addr;

  // Configuration registers and clamping.
  fbs_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  // Handshake: the output register is free or drains this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign col_ext    = CW'(col_r);
  assign w_last_ext = CW'(geom.w_last);
  assign row_ext    = RW'(row_r);
  assign h_last_ext = RW'(geom.h_last);

  assign at_row_end  = (col_ext == w_last_ext);
  assign at_last_row = (row_ext == h_last_ext);
  assign row_zero    = (row_r == '0);
  assign row_one     = (row_r == ROW_W'(1));
  assign edge_col    = (col_r == '0) || at_row_end;
  // Right neighbor of the second-to-last column is dropped from input row 3 on.
  assign right_edge_next = (col_ext + CW'(1) == w_last_ext) && (row_r > ROW_W'(2));
  assign emit = !row_zero;

  // Scan counters; a register write restarts the frame.
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    left_nxt = left_r;
    if (geom.restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      left_nxt = '0;
    end else if (accept) begin
      if (at_row_end) begin
        col_nxt  = '0;
        left_nxt = '0;
        row_nxt  = at_last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt  = col_r + COL_W'(1);
        left_nxt = result_px;
      end
    end
  end

  // Prefetch: row 1 copies the original top row in place, later rows read
  // the original right neighbor.
  assign orig_rd_addr = (row_nxt == ROW_W'(1)) ? col_nxt : col_nxt + COL_W'(1);

  fbs_row_mem #(.DEPTH(MAX_WIDTH)) u_above_mem (
    .clk     (clk),
    .wr_en   (accept && emit),
    .wr_addr (col_r),
    .wr_data (above_wr),
    .rd_addr (col_nxt),
    .rd_data (above_q)
  );

  fbs_row_mem #(.DEPTH(MAX_WIDTH)) u_orig_mem (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col_r),
    .wr_data (in_pixel_in),
    .rd_addr (orig_rd_addr),
    .rd_data (orig_q)
  );

  // Blur datapath.
  assign right_px  = right_edge_next ? '0 : orig_q;
  assign blur_px   = fbs_pkg::blur4(above_q, in_pixel_in, left_r, right_px);
  assign result_px = (row_zero || row_one || edge_col) ? '0 : blur_px;
  assign above_wr  = row_one ? orig_q : result_px;

  // Result register: load on an emitting accept, drop when taken.
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    pixel_out_nxt  = pixel_out_r;
    frame_done_nxt = frame_done_r;
    if (accept && emit) begin
      out_valid_nxt  = 1'b1;
      pixel_out_nxt  = result_px;
      frame_done_nxt = at_last_row && at_row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pixel_out_r  <= pixel_out_nxt;
    frame_done_r <= frame_done_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = pixel_out_r;
  assign out_frame_done = frame_done_r;

  // Counters stay inside the configured frame.
  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    col_ext <= w_last_ext) else $error("column counter beyond line width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    row_ext <= h_last_ext) else $error("row counter beyond frame height");

  // The frame-done word is in the right border column, so it is always zero.
  a_done_is_border: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> (out_pixel_out == '0))
    else $error("frame done on a nonzero word");

  // Any pixel past input row 0 must produce a word.
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !row_zero && !geom.restart) |=> out_valid)
    else $error("accepted pixel produced no word");

  // The left neighbor is cleared at the start of every row.
  a_left_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r == '0) |-> (left_r == '0)) else $error("stale left neighbor at row start");

endmodule
